>>> sv/tah_pkg.sv
// Shared widths, limits and the arctangent table for the tilt and heading angle block.
`default_nettype none

package tah_pkg;

	// Width of one input field as it travels on the bus.
	localparam int DATA_W = 16;
	// Sign-extended working width of an input value (holds -32768 .. 65535).
	localparam int EXT_W = 17;
	// Width of one squared magnitude.
	localparam int SQ_W = 32;
	// Square root: result bits and radicand width.
	localparam int ROOT_W = 28;
	localparam int RAD_W = 2 * ROOT_W;
	// CORDIC vector width, angle accumulator width and result angle width.
	localparam int CW = 32;
	localparam int ZW = 26;
	localparam int ANG_W = 16;
	localparam int TILT_W = 15;
	// Fine-angle fractional bits dropped at the end (65536 units down to 128).
	localparam int DROP_W = 9;

	// Defaults of the top-level parameters.
	localparam int INPUT_WIDTH_DEF = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN = 24;

	// Angle limits in degrees times 128, and ninety degrees in fine units.
	localparam logic signed [ANG_W-1:0] ANG_LIM_TILT = 16'sd11520;
	localparam logic signed [ANG_W-1:0] ANG_LIM_HEAD = 16'sd23040;
	localparam logic signed [ZW-1:0] DEG90_FINE = 26'sd5898240;

	// atan(2^-i) in degrees times 65536, rounded to nearest.
	function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
		logic signed [ZW-1:0] val;
		unique case (idx)
			5'd0: val = 26'sd2949120;
			5'd1: val = 26'sd1740967;
			5'd2: val = 26'sd919879;
			5'd3: val = 26'sd466945;
			5'd4: val = 26'sd234379;
			5'd5: val = 26'sd117304;
			5'd6: val = 26'sd58666;
			5'd7: val = 26'sd29335;
			5'd8: val = 26'sd14668;
			5'd9: val = 26'sd7334;
			5'd10: val = 26'sd3667;
			5'd11: val = 26'sd1833;
			5'd12: val = 26'sd917;
			5'd13: val = 26'sd458;
			5'd14: val = 26'sd229;
			5'd15: val = 26'sd115;
			5'd16: val = 26'sd57;
			5'd17: val = 26'sd29;
			5'd18: val = 26'sd14;
			5'd19: val = 26'sd7;
			5'd20: val = 26'sd4;
			5'd21: val = 26'sd2;
			5'd22: val = 26'sd1;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

>>> sv/tah_cordic.sv
// One pipelined vectoring CORDIC lane: special cases, quadrant fold, stages and rounding.
`default_nettype none

module tah_cordic #(
	parameter int STAGES = tah_pkg::CORDIC_STAGES_DEF,
	parameter logic signed [tah_pkg::ANG_W-1:0] LIM = tah_pkg::ANG_LIM_TILT
) (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic signed [tah_pkg::CW-1:0]        num,
	input  wire logic signed [tah_pkg::CW-1:0]        den,
	output logic signed [tah_pkg::ANG_W-1:0]          angle,
	output logic                                      degen
);

	localparam int CW = tah_pkg::CW;
	localparam int ZW = tah_pkg::ZW;
	localparam int ANG_W = tah_pkg::ANG_W;
	localparam int RW = ZW + 1 - tah_pkg::DROP_W;

	typedef struct packed {
		logic                    special;
		logic                    degen;
		logic signed [ANG_W-1:0] value;
	} spec_t;

	logic signed [CW-1:0] pn, pd;
	logic signed [ZW-1:0] pz;
	spec_t                pspec;

	logic signed [CW-1:0] n_s [0:STAGES];
	logic signed [CW-1:0] d_s [0:STAGES];
	logic signed [ZW-1:0] z_s [0:STAGES];
	spec_t                sp_s [0:STAGES];

	logic signed [ZW:0]   zr;
	logic signed [RW-1:0] zrnd;
	logic signed [RW-1:0] lim_w;
	logic signed [ANG_W-1:0] sat_val;

	// Special cases first, then fold a vector with negative denominator by ninety degrees.
	always_comb begin
		pspec = '0;
		pn = num;
		pd = den;
		pz = '0;
		priority if (num == '0 && den == '0) begin
			pspec.special = 1'b1;
			pspec.degen = 1'b1;
		end else if (den == '0) begin
			pspec.special = 1'b1;
			pspec.value = num[CW-1] ? -tah_pkg::ANG_LIM_TILT : tah_pkg::ANG_LIM_TILT;
		end else if (num == '0) begin
			pspec.special = 1'b1;
			pspec.value = den[CW-1] ? tah_pkg::ANG_LIM_HEAD : '0;
		end else if (den[CW-1]) begin
			if (!num[CW-1]) begin
				pn = -den;
				pd = num;
				pz = tah_pkg::DEG90_FINE;
			end else begin
				pn = den;
				pd = -num;
				pz = -tah_pkg::DEG90_FINE;
			end
		end else begin
			pz = '0;
		end
	end

	// Entry register of the lane.
	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= pn;
			d_s[0] <= pd;
			z_s[0] <= pz;
			sp_s[0] <= pspec;
		end
	end

	// One micro-rotation per stage; the sign of the numerator picks the direction.
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [CW-1:0] dd, dn;
		logic signed [ZW-1:0] at;
		assign dd = d_s[i] >>> i;
		assign dn = n_s[i] >>> i;
		assign at = tah_pkg::atan_entry(5'(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!n_s[i][CW-1]) begin
					d_s[i+1] <= d_s[i] + dn;
					n_s[i+1] <= n_s[i] - dd;
					z_s[i+1] <= z_s[i] + at;
				end else begin
					d_s[i+1] <= d_s[i] - dn;
					n_s[i+1] <= n_s[i] + dd;
					z_s[i+1] <= z_s[i] - at;
				end
				sp_s[i+1] <= sp_s[i];
			end
		end
	end

	// Round the fine angle to 1/128 degree and clamp it.
	assign zr = (ZW+1)'(z_s[STAGES]) + (ZW+1)'(256);
	assign zrnd = RW'(zr >>> tah_pkg::DROP_W);
	assign lim_w = RW'(LIM);

	always_comb begin
		priority if (zrnd > lim_w) begin
			sat_val = LIM;
		end else if (zrnd < -lim_w) begin
			sat_val = -LIM;
		end else begin
			sat_val = ANG_W'(zrnd);
		end
	end

	// Result register of the lane.
	always_ff @(posedge clk) begin
		if (en) begin
			angle <= sp_s[STAGES].special ? sp_s[STAGES].value : sat_val;
			degen <= sp_s[STAGES].degen;
		end
	end

endmodule

`default_nettype wire

>>> sv/tilt_and_heading_angles.sv
// Top level: pitch, roll and heading angles of one three-axis vector per word.
//
// The block takes one signed (x, y, z) word per clock and returns pitch and roll
// (+-90 degrees) and heading atan2(y, x) (+-180 degrees), all in 1/128 degree,
// plus a flag in m_tuser when an angle had zero numerator and denominator. It
// accepts a new word in every cycle that the output is not stalled. The pipeline
// runs through a sign extension stage, a squaring stage and a summing stage,
// 28 digit stages of the restoring square root, then one fold stage,
// CORDIC_STAGES rotation stages and one rounding stage in each of three
// parallel CORDIC lanes. A stall on m_tready holds the whole pipeline in
// place; nothing is lost or repeated.
`default_nettype none

module tilt_and_heading_angles #(
	parameter int INPUT_WIDTH = tah_pkg::INPUT_WIDTH_DEF,
	parameter int CORDIC_STAGES = tah_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// axis_x [15:0], axis_y [31:16], axis_z [47:32]
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// pitch_angle [14:0], roll_angle [29:15], heading_angle [45:30], zero pad [47:46]
	output logic [47:0]      m_tdata,
	// degenerate
	output logic             m_tuser
);

	localparam int DATA_W = tah_pkg::DATA_W;
	localparam int EXT_W = tah_pkg::EXT_W;
	localparam int SQ_W = tah_pkg::SQ_W;
	localparam int ROOT_W = tah_pkg::ROOT_W;
	localparam int RAD_W = tah_pkg::RAD_W;
	localparam int CW = tah_pkg::CW;
	localparam int ANG_W = tah_pkg::ANG_W;
	localparam int TILT_W = tah_pkg::TILT_W;
	localparam int PRESHIFT = (INPUT_WIDTH < 28) ? 28 - INPUT_WIDTH : 0;
	localparam int LAT = 3 + ROOT_W + CORDIC_STAGES + 2;

	logic en;
	logic [LAT-1:0] vld_q;

	logic signed [EXT_W-1:0] xe, ye, ze;
	logic signed [EXT_W-1:0] x_s1, y_s1, z_s1;
	logic [DATA_W-1:0]       xm, ym, zm;
	logic [SQ_W-1:0]         xsq_s2, ysq_s2, zsq_s2;
	logic signed [EXT_W-1:0] x_s2, y_s2;

	logic [RAD_W-1:0]        prem_s [0:ROOT_W];
	logic [RAD_W-1:0]        pres_s [0:ROOT_W];
	logic [RAD_W-1:0]        rrem_s [0:ROOT_W];
	logic [RAD_W-1:0]        rres_s [0:ROOT_W];
	logic signed [EXT_W-1:0] sx_s [0:ROOT_W];
	logic signed [EXT_W-1:0] sy_s [0:ROOT_W];

	logic signed [CW-1:0]    num_x, num_y, den_p, den_r;
	logic signed [ANG_W-1:0] pitch, roll, heading;
	logic                    dg_p, dg_r, dg_h;

	// The whole pipeline moves unless a finished word waits at the output.
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Sign-extend from the configured input width; wider settings read as unsigned.
	if (INPUT_WIDTH <= DATA_W) begin : g_sext
		assign xe = EXT_W'($signed(s_tdata[INPUT_WIDTH-1:0]));
		assign ye = EXT_W'($signed(s_tdata[DATA_W+INPUT_WIDTH-1:DATA_W]));
		assign ze = EXT_W'($signed(s_tdata[2*DATA_W+INPUT_WIDTH-1:2*DATA_W]));
	end else begin : g_zext
		assign xe = $signed({1'b0, s_tdata[DATA_W-1:0]});
		assign ye = $signed({1'b0, s_tdata[2*DATA_W-1:DATA_W]});
		assign ze = $signed({1'b0, s_tdata[3*DATA_W-1:2*DATA_W]});
	end

	// Stage 1: capture the extended components.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= xe;
			y_s1 <= ye;
			z_s1 <= ze;
		end
	end

	// Stage 2: magnitudes squared.
	assign xm = x_s1[EXT_W-1] ? DATA_W'(-x_s1) : DATA_W'(x_s1);
	assign ym = y_s1[EXT_W-1] ? DATA_W'(-y_s1) : DATA_W'(y_s1);
	assign zm = z_s1[EXT_W-1] ? DATA_W'(-z_s1) : DATA_W'(z_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			xsq_s2 <= xm * xm;
			ysq_s2 <= ym * ym;
			zsq_s2 <= zm * zm;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
		end
	end

	// Stage 3: scaled radicands for the pitch and roll denominators.
	always_ff @(posedge clk) begin
		if (en) begin
			prem_s[0] <= (RAD_W'(ysq_s2) + RAD_W'(zsq_s2)) << (2 * PRESHIFT);
			rrem_s[0] <= (RAD_W'(xsq_s2) + RAD_W'(zsq_s2)) << (2 * PRESHIFT);
			pres_s[0] <= '0;
			rres_s[0] <= '0;
			sx_s[0] <= x_s2;
			sy_s[0] <= y_s2;
		end
	end

	// Restoring square root, one result bit per stage, both radicands side by side.
	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		localparam logic [RAD_W-1:0] BITV = RAD_W'(1) << (2 * (ROOT_W - 1 - j));
		logic [RAD_W-1:0] ptry, rtry;
		assign ptry = pres_s[j] + BITV;
		assign rtry = rres_s[j] + BITV;
		always_ff @(posedge clk) begin
			if (en) begin
				if (prem_s[j] >= ptry) begin
					prem_s[j+1] <= prem_s[j] - ptry;
					pres_s[j+1] <= (pres_s[j] >> 1) + BITV;
				end else begin
					prem_s[j+1] <= prem_s[j];
					pres_s[j+1] <= pres_s[j] >> 1;
				end
				if (rrem_s[j] >= rtry) begin
					rrem_s[j+1] <= rrem_s[j] - rtry;
					rres_s[j+1] <= (rres_s[j] >> 1) + BITV;
				end else begin
					rrem_s[j+1] <= rrem_s[j];
					rres_s[j+1] <= rres_s[j] >> 1;
				end
				sx_s[j+1] <= sx_s[j];
				sy_s[j+1] <= sy_s[j];
			end
		end
	end

	// Operands of the three lanes.
	assign num_x = CW'(sx_s[ROOT_W]) <<< PRESHIFT;
	assign num_y = CW'(sy_s[ROOT_W]) <<< PRESHIFT;
	assign den_p = CW'(pres_s[ROOT_W][ROOT_W-1:0]);
	assign den_r = CW'(rres_s[ROOT_W][ROOT_W-1:0]);

	tah_cordic #(.STAGES(CORDIC_STAGES), .LIM(tah_pkg::ANG_LIM_TILT)) u_pitch (
		.clk(clk), .en(en),
		.num(num_x), .den(den_p), .angle(pitch), .degen(dg_p)
	);

	tah_cordic #(.STAGES(CORDIC_STAGES), .LIM(tah_pkg::ANG_LIM_TILT)) u_roll (
		.clk(clk), .en(en),
		.num(num_y), .den(den_r), .angle(roll), .degen(dg_r)
	);

	tah_cordic #(.STAGES(CORDIC_STAGES), .LIM(tah_pkg::ANG_LIM_HEAD)) u_head (
		.clk(clk), .en(en),
		.num(num_y), .den(num_x), .angle(heading), .degen(dg_h)
	);

	// Pack the result word.
	assign m_tdata = {2'b00, heading, roll[TILT_W-1:0], pitch[TILT_W-1:0]};
	assign m_tuser = dg_p || dg_r || dg_h;

	// A degenerate vector yields zero for every angle.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (pitch == '0 && roll == '0 && heading == '0))
		else $error("degenerate word with nonzero angle");

	// Tilt angles stay within ninety degrees.
	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pitch <= tah_pkg::ANG_LIM_TILT && pitch >= -tah_pkg::ANG_LIM_TILT
			&& roll <= tah_pkg::ANG_LIM_TILT && roll >= -tah_pkg::ANG_LIM_TILT))
		else $error("tilt angle out of range");

	// Heading stays within one hundred eighty degrees.
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (heading <= tah_pkg::ANG_LIM_HEAD && heading >= -tah_pkg::ANG_LIM_HEAD))
		else $error("heading out of range");

	// A stall freezes the valid chain.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid chain moved during a stall");

endmodule

`default_nettype wire

>>> verif/tilt_and_heading_angles_chk.sv
// Checker for the tilt and heading angle block: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module tilt_and_heading_angles_chk (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,
	input  wire logic        m_tuser,
	output int               fail_count,
	output int               pending,
	output int               seen_count,
	output int               degen_count
);

	localparam int PRE = 28 - tah_pkg::INPUT_WIDTH_DEF;
	localparam int TILT_W = tah_pkg::TILT_W;
	localparam int ANG_W = tah_pkg::ANG_W;

	typedef struct packed {
		logic [TILT_W-1:0] pitch;
		logic [TILT_W-1:0] roll;
		logic [ANG_W-1:0]  heading;
		logic              degen;
	} angles_t;

	angles_t angles_due[$];

	// Arithmetic shift right with floor.
	function automatic longint floor_shr(input longint v, input int s);
		return v >>> s;
	endfunction

	// Integer square root by the digit method.
	function automatic longint int_root(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint tilt_len(input longint a, input longint b);
		longint unsigned ua, ub;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		return int_root((ua * ua + ub * ub) << (2 * PRE));
	endfunction

	function automatic longint clamp(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Vectoring CORDIC angle of (d, n) in degrees times 128, unsaturated.
	function automatic longint vec_angle(input longint n, input longint d, inout logic dg);
		longint acc, t, dd, dn;
		acc = 0;
		if (n == 0 && d == 0) begin
			dg = 1'b1;
			return 0;
		end
		if (d == 0) return (n > 0) ? 11520 : -11520;
		if (n == 0) return (d > 0) ? 0 : 23040;
		if (d < 0) begin
			t = n;
			if (n > 0) begin
				n = -d; d = t; acc = 90 * 65536;
			end else begin
				n = d; d = -t; acc = -90 * 65536;
			end
		end
		for (int i = 0; i < tah_pkg::CORDIC_STAGES_DEF && i < tah_pkg::ATAN_LEN; i++) begin
			dd = floor_shr(d, i);
			dn = floor_shr(n, i);
			if (n >= 0) begin
				d += dn; n -= dd; acc += longint'(tah_pkg::atan_entry(5'(i)));
			end else begin
				d -= dn; n += dd; acc -= longint'(tah_pkg::atan_entry(5'(i)));
			end
		end
		return floor_shr(acc + 256, tah_pkg::DROP_W);
	endfunction

	function automatic angles_t predict_angles(input logic [47:0] w);
		longint x, y, z, sc;
		logic dg;
		angles_t r;
		x = longint'($signed(w[15:0]));
		y = longint'($signed(w[31:16]));
		z = longint'($signed(w[47:32]));
		sc = 64'sd1 << PRE;
		dg = 1'b0;
		r.pitch = TILT_W'(clamp(vec_angle(x * sc, tilt_len(y, z), dg), 11520));
		r.roll = TILT_W'(clamp(vec_angle(y * sc, tilt_len(x, z), dg), 11520));
		r.heading = ANG_W'(clamp(vec_angle(y * sc, x * sc, dg), 23040));
		r.degen = dg;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = angles_due.size();

	// Queue predictions on accepted input words; compare accepted result words.
	always @(posedge clk or negedge arst_n) begin
		angles_t want;
		if (!arst_n) begin
			fail_count = 0;
			seen_count <= 0;
			degen_count <= 0;
			angles_due.delete();
		end else begin
			if (s_tvalid && s_tready)
				angles_due.push_back(predict_angles(s_tdata));
			if (m_tvalid && m_tready) begin
				seen_count <= seen_count + 1;
				if (m_tuser) degen_count <= degen_count + 1;
				if (angles_due.size() == 0) begin
					report_mismatch("unexpected word", 1, 0);
				end else begin
					want = angles_due.pop_front();
					if (m_tdata[14:0] !== want.pitch)
						report_mismatch("pitch", $signed(m_tdata[14:0]), $signed(want.pitch));
					if (m_tdata[29:15] !== want.roll)
						report_mismatch("roll", $signed(m_tdata[29:15]), $signed(want.roll));
					if (m_tdata[45:30] !== want.heading)
						report_mismatch("heading", $signed(m_tdata[45:30]),
							$signed(want.heading));
					if (m_tuser !== want.degen)
						report_mismatch("degenerate", m_tuser, want.degen);
				end
			end
		end
	end
endmodule

>>> verif/tilt_and_heading_angles_tb.sv
// Testbench top for the tilt and heading angle block: stimulus, idling phases and verdict.
`timescale 1ns / 100ps

module tilt_and_heading_angles_tb;
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;
	int          fail_count, pending, seen_count, degen_count;
	int          send_idle_pct, recv_stall_pct;

	tilt_and_heading_angles DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	tilt_and_heading_angles_chk CHK (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending),
		.seen_count(seen_count), .degen_count(degen_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random by the current phase's percentage.
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Random axis value: uniform half the time, else an extreme, a small value or zero.
	function automatic logic [15:0] pick_axis();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(6)) - 3);
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one word and hold it until accepted; valid drops only in idle cycles.
	task automatic send_word(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	initial begin
		logic [15:0] dir[$];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all zero, each axis alone at both extremes, sign cases of heading.
		dir = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff};
		foreach (dir[i]) send_word(dir[i], 16'h0000, 16'h0000);
		foreach (dir[i]) send_word(16'h0000, dir[i], 16'h0000);
		foreach (dir[i]) send_word(16'h0000, 16'h0000, dir[i]);
		send_word(16'h8000, 16'h8000, 16'h8000);
		send_word(16'h7fff, 16'h7fff, 16'h7fff);
		send_word(16'h8000, 16'h7fff, 16'h0000);
		send_word(16'h8000, 16'h8000, 16'h0001);
		send_word(16'hffff, 16'h0001, 16'h0000);
		send_word(16'hffff, 16'hffff, 16'h0000);
		send_word(16'h0005, 16'hfffb, 16'h0000);
		send_word(16'haaaa, 16'h5555, 16'hffff);

		// Pause until everything in flight has come back.
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		// Random phases with different idling.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
				3: begin send_idle_pct = 29; recv_stall_pct = 29; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			repeat (380) send_word(pick_axis(), pick_axis(), pick_axis());
			if (ph == 2) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end

		s_tvalid <= 1'b0;
		recv_stall_pct = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Covered %0d result words (%0d degenerate) over five idling phases.",
			seen_count, degen_count);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
